@@ hdl/pwcd_pkg.sv @@
// Shared types, constants and the fractional log table for the posterior window detector.
package pwcd_pkg;

   // Frame and result field widths
   localparam int NUM_CLASSES = 5;
   localparam int PROB_W      = 16;
   localparam int LEAD_W      = $clog2(PROB_W);
   localparam int FRAC_BITS   = 8;
   localparam int FRAC_W      = 10;
   localparam int LOG_W       = 15;
   localparam int SUM_W       = 19;
   localparam int CLASS_W     = 3;
   localparam int TIME_W      = 32;
   localparam int COOL_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int MAG_PROD_W  = 28;
   localparam int MAG_SHIFT   = 14;

   // ln2 in Q24 and the rounding offset for the Q24 -> Q10 step
   localparam logic [23:0] LN2_Q24 = 24'd11629080;
   localparam logic [MAG_PROD_W-1:0] MAG_ROUND = MAG_PROD_W'(8192);

   // round(1024 * ln(1e-6)), used for every class of a bad frame
   localparam logic signed [LOG_W-1:0] INVALID_LOG = -15'sd14147;

   // Register reset values
   localparam logic signed [SUM_W-1:0] THRESHOLD_RESET = -19'sd3072;
   localparam logic [COOL_W-1:0]       COOLDOWN_RESET  = 16'd1000;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_COOLDOWN  = 2'd1
   } csr_index_type;

   typedef logic signed [LOG_W-1:0] log_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   // Per-step strobes from the sequencer to every lane
   typedef struct packed {
      logic load_log;
      logic accumulate;
   } lane_ctrl_type;

   // round(1024 * ln(1 + f/256)), f = 0..255
   localparam logic [FRAC_W-1:0] FRAC_LOG_TABLE [256] = '{
      10'd0,   10'd4,   10'd8,   10'd12,  10'd16,  10'd20,  10'd24,  10'd28,
      10'd32,  10'd35,  10'd39,  10'd43,  10'd47,  10'd51,  10'd55,  10'd58,
      10'd62,  10'd66,  10'd70,  10'd73,  10'd77,  10'd81,  10'd84,  10'd88,
      10'd92,  10'd95,  10'd99,  10'd103, 10'd106, 10'd110, 10'd113, 10'd117,
      10'd121, 10'd124, 10'd128, 10'd131, 10'd135, 10'd138, 10'd142, 10'd145,
      10'd149, 10'd152, 10'd156, 10'd159, 10'd162, 10'd166, 10'd169, 10'd173,
      10'd176, 10'd179, 10'd183, 10'd186, 10'd189, 10'd193, 10'd196, 10'd199,
      10'd203, 10'd206, 10'd209, 10'd212, 10'd216, 10'd219, 10'd222, 10'd225,
      10'd228, 10'd232, 10'd235, 10'd238, 10'd241, 10'd244, 10'd248, 10'd251,
      10'd254, 10'd257, 10'd260, 10'd263, 10'd266, 10'd269, 10'd272, 10'd275,
      10'd278, 10'd282, 10'd285, 10'd288, 10'd291, 10'd294, 10'd297, 10'd300,
      10'd303, 10'd306, 10'd308, 10'd311, 10'd314, 10'd317, 10'd320, 10'd323,
      10'd326, 10'd329, 10'd332, 10'd335, 10'd338, 10'd341, 10'd343, 10'd346,
      10'd349, 10'd352, 10'd355, 10'd358, 10'd360, 10'd363, 10'd366, 10'd369,
      10'd372, 10'd374, 10'd377, 10'd380, 10'd383, 10'd385, 10'd388, 10'd391,
      10'd394, 10'd396, 10'd399, 10'd402, 10'd404, 10'd407, 10'd410, 10'd413,
      10'd415, 10'd418, 10'd421, 10'd423, 10'd426, 10'd428, 10'd431, 10'd434,
      10'd436, 10'd439, 10'd442, 10'd444, 10'd447, 10'd449, 10'd452, 10'd454,
      10'd457, 10'd460, 10'd462, 10'd465, 10'd467, 10'd470, 10'd472, 10'd475,
      10'd477, 10'd480, 10'd482, 10'd485, 10'd487, 10'd490, 10'd492, 10'd495,
      10'd497, 10'd500, 10'd502, 10'd505, 10'd507, 10'd509, 10'd512, 10'd514,
      10'd517, 10'd519, 10'd521, 10'd524, 10'd526, 10'd529, 10'd531, 10'd533,
      10'd536, 10'd538, 10'd541, 10'd543, 10'd545, 10'd548, 10'd550, 10'd552,
      10'd555, 10'd557, 10'd559, 10'd562, 10'd564, 10'd566, 10'd568, 10'd571,
      10'd573, 10'd575, 10'd578, 10'd580, 10'd582, 10'd584, 10'd587, 10'd589,
      10'd591, 10'd593, 10'd596, 10'd598, 10'd600, 10'd602, 10'd605, 10'd607,
      10'd609, 10'd611, 10'd613, 10'd616, 10'd618, 10'd620, 10'd622, 10'd624,
      10'd626, 10'd629, 10'd631, 10'd633, 10'd635, 10'd637, 10'd639, 10'd642,
      10'd644, 10'd646, 10'd648, 10'd650, 10'd652, 10'd654, 10'd656, 10'd659,
      10'd661, 10'd663, 10'd665, 10'd667, 10'd669, 10'd671, 10'd673, 10'd675,
      10'd677, 10'd679, 10'd681, 10'd683, 10'd685, 10'd688, 10'd690, 10'd692,
      10'd694, 10'd696, 10'd698, 10'd700, 10'd702, 10'd704, 10'd706, 10'd708
   };

endpackage

@@ hdl/posterior_window_command_detector.sv @@
// Top level of the posterior window command detector.
// Usage:
//   req_* carries one classifier frame per beat: five Q0.16 class probabilities,
//   a frame valid flag and a millisecond timestamp. A beat is taken when
//   req_valid is high and req_stall is low.
//   rsp_* returns exactly one beat per frame: the detect flag, the best class and
//   its window log sum (signed Q9.10). The receiver holds it off with rsp_stall.
//   csr_* writes the score threshold (index 0) and the cooldown (index 1);
//   csr_ready is always high. Write only while no frame is in flight.
// Sequencing:
//   A taken frame passes the sequencer's log stage, window accumulate, merge
//   and decision steps in order; req_stall stays high until it leaves the
//   decision step, so no new frame is taken while one is in flight. A held
//   result does not block the next frame, which runs up to the decision step
//   and waits there until the output register frees.
// Reset (synchronous): window history reads as zero, window slot and last
//   detection time clear, threshold returns to -3072 and cooldown to 1000 ms.
module posterior_window_command_detector import pwcd_pkg::*; #(
   parameter int WINDOW_DEPTH = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PROB_W-1:0]      req_class0_prob,
   input  logic [PROB_W-1:0]      req_class1_prob,
   input  logic [PROB_W-1:0]      req_class2_prob,
   input  logic [PROB_W-1:0]      req_class3_prob,
   input  logic [PROB_W-1:0]      req_class4_prob,
   input  logic                   req_frame_valid,
   input  logic [TIME_W-1:0]      req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_detected,
   output logic [CLASS_W-1:0]     rsp_best_class,
   output logic [SUM_W-1:0]       rsp_best_sum,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SUM_W-1:0]       csr_data
);

   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOG,
      ST_ACC,
      ST_MERGE,
      ST_DECIDE
   } state_type;

   state_type          state_ff, state_in;
   logic               accept;
   logic               rsp_free;
   logic               hit;
   logic [TIME_W-1:0]  elapsed;
   lane_ctrl_type      lane_ctrl;
   logic               merge_start;
   sum_type            sums [NUM_CLASSES];
   logic [CLASS_W-1:0] best_class;
   sum_type            best_sum;

   logic [PROB_W-1:0]  prob_ff [NUM_CLASSES];
   logic               frame_valid_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [TIME_W-1:0]  last_detect_ff;
   sum_type            threshold_ff;
   logic [COOL_W-1:0]  cooldown_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_detected_ff;
   logic [CLASS_W-1:0] rsp_class_ff;
   sum_type            rsp_sum_ff;

   // Handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Step strobes
   assign lane_ctrl.load_log   = (state_ff == ST_LOG);
   assign lane_ctrl.accumulate = (state_ff == ST_ACC);
   assign merge_start          = (state_ff == ST_MERGE);

   // Detection rule: above threshold, not the noise class, cooldown passed
   assign elapsed = now_ff - last_detect_ff;
   assign hit     = (best_sum > threshold_ff)
                 && (best_class != CLASS_W'(NUM_CLASSES - 1))
                 && (elapsed > TIME_W'(cooldown_ff));

   assign slot_in = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   // Sequencer next state and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_MERGE;
         ST_MERGE: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // State, registered outputs, window slot, detection time and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         slot_ff        <= '0;
         last_detect_ff <= '0;
         threshold_ff   <= THRESHOLD_RESET;
         cooldown_ff    <= COOLDOWN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (lane_ctrl.accumulate) begin
            slot_ff <= slot_in;
         end
         if (state_ff == ST_DECIDE && rsp_free) begin
            rsp_detected_ff <= hit;
            rsp_class_ff    <= best_class;
            rsp_sum_ff      <= best_sum;
            if (hit) begin
               last_detect_ff <= now_ff;
            end
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_THRESHOLD: threshold_ff <= csr_data;
               CSR_COOLDOWN:  cooldown_ff  <= csr_data[COOL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Input beat capture
   always_ff @(posedge clock) begin
      if (accept) begin
         prob_ff[0]     <= req_class0_prob;
         prob_ff[1]     <= req_class1_prob;
         prob_ff[2]     <= req_class2_prob;
         prob_ff[3]     <= req_class3_prob;
         prob_ff[4]     <= req_class4_prob;
         frame_valid_ff <= req_frame_valid;
         now_ff         <= req_now_ms;
      end
   end

   // One lane per class
   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_lane
      pwcd_lane #(
         .WINDOW_DEPTH(WINDOW_DEPTH)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (lane_ctrl),
         .prob        (prob_ff[g]),
         .frame_valid (frame_valid_ff),
         .slot        (slot_ff),
         .window_sum  (sums[g])
      );
   end

   pwcd_merge u_merge (
      .clock      (clock),
      .start      (merge_start),
      .sums       (sums),
      .best_class (best_class),
      .best_sum   (best_sum)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_detected   = rsp_detected_ff;
   assign rsp_best_class = rsp_class_ff;
   assign rsp_best_sum   = rsp_sum_ff;

endmodule

@@ hdl/pwcd_lane.sv @@
// One class lane: probability to log, window history row and running window sum.
module pwcd_lane import pwcd_pkg::*; #(
   parameter int WINDOW_DEPTH = 5,
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  lane_ctrl_type     ctrl,
   input  logic [PROB_W-1:0] prob,
   input  logic              frame_valid,
   input  logic [SLOT_W-1:0] slot,
   output sum_type           window_sum
);

   logic [PROB_W-1:0]           p_eff;
   logic [LEAD_W-1:0]           lead;
   logic [PROB_W+FRAC_BITS-1:0] shifted;
   logic [FRAC_BITS-1:0]        frac_idx;
   logic [LEAD_W:0]             mag_scale;
   logic [MAG_PROD_W-1:0]       mag_prod;
   logic [LOG_W-2:0]            mag;
   log_type                     log_in, log_ff;
   log_type                     old_in, old_ff;
   log_type                     ring_ff [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]     row_valid_ff;
   sum_type                     sum_in, sum_ff;

   // Log of the probability: leading one, 8 fraction bits, table minus exponent term
   always_comb begin
      p_eff = (prob == '0) ? PROB_W'(1) : prob;
      lead  = '0;
      for (int i = 0; i < PROB_W; i++) begin
         if (p_eff[i]) begin
            lead = LEAD_W'(i);
         end
      end
      shifted   = {p_eff, FRAC_BITS'(0)} >> lead;
      frac_idx  = shifted[FRAC_BITS-1:0];
      mag_scale = (LEAD_W+1)'(PROB_W) - {1'b0, lead};
      mag_prod  = MAG_PROD_W'(mag_scale) * MAG_PROD_W'(LN2_Q24) + MAG_ROUND;
      mag       = mag_prod[MAG_PROD_W-1:MAG_SHIFT];
      if (frame_valid) begin
         log_in = $signed({(LOG_W-FRAC_W)'(0), FRAC_LOG_TABLE[frac_idx]})
                - $signed({1'b0, mag});
      end else begin
         log_in = INVALID_LOG;
      end
   end

   // Entry leaving the window; a row never written reads as zero
   assign old_in = row_valid_ff[slot] ? ring_ff[slot] : '0;

   // Running sum: add the new log, drop the one it replaces
   assign sum_in = sum_ff + SUM_W'(log_ff) - SUM_W'(old_ff);

   // Control state: row valid bits and the window sum
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         sum_ff       <= '0;
      end else if (ctrl.accumulate) begin
         row_valid_ff[slot] <= 1'b1;
         sum_ff             <= sum_in;
      end
   end

   // Payload: log stage and history row
   always_ff @(posedge clock) begin
      if (ctrl.load_log) begin
         log_ff <= log_in;
         old_ff <= old_in;
      end
      if (ctrl.accumulate) begin
         ring_ff[slot] <= log_ff;
      end
   end

   assign window_sum = sum_ff;

endmodule

@@ hdl/pwcd_merge.sv @@
// Merge stage: picks the first class with the largest window sum.
module pwcd_merge import pwcd_pkg::*; (
   input  logic               clock,
   input  logic               start,
   input  sum_type            sums [NUM_CLASSES],
   output logic [CLASS_W-1:0] best_class,
   output sum_type            best_sum
);

   logic [CLASS_W-1:0] class_in, class_ff;
   sum_type            best_in, best_ff;

   // Compare chain; strict greater keeps the lowest index on ties
   always_comb begin
      class_in = '0;
      best_in  = sums[0];
      for (int j = 1; j < NUM_CLASSES; j++) begin
         if (sums[j] > best_in) begin
            best_in  = sums[j];
            class_in = CLASS_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         class_ff <= class_in;
         best_ff  <= best_in;
      end
   end

   assign best_class = class_ff;
   assign best_sum   = best_ff;

endmodule

@@ hdl/pwcd_checker.sv @@
// Port-level checks for the posterior window command detector, bound to the top level.
module pwcd_port_checks import pwcd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_detected,
   input logic [CLASS_W-1:0] rsp_best_class,
   input logic [SUM_W-1:0]   rsp_best_sum
);

   // A taken frame keeps the input side busy for the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous frame still in flight");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present right after reset");

   // A held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_detected)
         && $stable(rsp_best_class) && $stable(rsp_best_sum))
      else $error("stalled result beat changed or dropped");

   // Class in range, and the noise class never detects
   a_class_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_class < CLASS_W'(NUM_CLASSES))
         && (!rsp_detected || rsp_best_class != CLASS_W'(NUM_CLASSES - 1)))
      else $error("best class out of range or noise class detected");

   // Logs of probabilities are never positive, so neither is any window sum
   a_sum_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_best_sum[SUM_W-1] || (rsp_best_sum == '0))
      else $error("positive window sum reported");

endmodule

bind posterior_window_command_detector pwcd_port_checks u_pwcd_checker (.*);

@@ bench/pwcd_checker.sv @@
// Checker for the posterior window detector: predicts every frame's decision and compares results.
module pwcd_checker import pwcd_pkg::*; #(
   parameter int WINDOW_DEPTH = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [PROB_W-1:0]      req_class0_prob,
   input  logic [PROB_W-1:0]      req_class1_prob,
   input  logic [PROB_W-1:0]      req_class2_prob,
   input  logic [PROB_W-1:0]      req_class3_prob,
   input  logic [PROB_W-1:0]      req_class4_prob,
   input  logic                   req_frame_valid,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_detected,
   input  logic [CLASS_W-1:0]     rsp_best_class,
   input  logic [SUM_W-1:0]       rsp_best_sum,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SUM_W-1:0]       csr_data,
   output int unsigned            error_count,
   output int unsigned            outstanding,
   output int unsigned            results_checked,
   output int unsigned            detections_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] LN2_Q24_SCALED = 64'd11629080;  // ln2 * 2^24
   localparam int          FLOOR_LOG      = -14147;         // ln(1e-6) in Q5.10

   typedef struct packed {
      logic               detected;
      logic [CLASS_W-1:0] best_class;
      logic [SUM_W-1:0]   best_sum;
   } decision_type;

   decision_type pending_decisions [$];

   // Shadow of the block's window history and registers
   log_type           window_logs [WINDOW_DEPTH][NUM_CLASSES];
   int unsigned       write_row;
   logic [TIME_W-1:0] last_hit_ms;
   sum_type           score_floor;
   logic [COOL_W-1:0] holdoff_ms;

   // round(1024 * ln(1 + f/256)) by the atanh series in Q32
   function automatic int unsigned frac_ln_q10(input int unsigned f);
      logic [63:0] y;
      logic [63:0] y2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] n;
      if (f == 0) return 0;
      y    = (64'(f) << 32) / 64'(512 + f);
      y2   = (y * y) >> 32;
      term = y;
      acc  = 0;
      n    = 1;
      while (term != 0) begin
         acc  = acc + term / n;
         term = (term * y2) >> 32;
         n    = n + 2;
      end
      return 32'((2 * acc + (64'd1 << 21)) >> 22);
   endfunction

   // Natural log of a Q0.16 probability in Q5.10; zero counts as one LSB
   function automatic int prob_ln_q10(input logic [PROB_W-1:0] p);
      int unsigned v;
      int unsigned k;
      int unsigned f;
      logic [63:0] mag;
      v = (p == 0) ? 1 : 32'(p);
      k = 0;
      while (k < 15 && (v >> (k + 1)) != 0) k++;
      if (k >= 8) f = (v >> (k - 8)) & 255;
      else f = (v << (8 - k)) & 255;
      mag = (64'(16 - k) * LN2_Q24_SCALED + 64'd8192) >> 14;
      return int'(frac_ln_q10(f)) - int'(mag);
   endfunction

   // Store the frame's logs, sum the window and make the detect decision
   function automatic decision_type window_decision(
                                                 input logic [NUM_CLASSES*PROB_W-1:0] probs,
                                                 input logic frame_ok,
                                                 input logic [TIME_W-1:0] now_ms);
      int           sums [NUM_CLASSES];
      int           top_sum;
      int unsigned  top_class;
      decision_type d;
      for (int j = 0; j < NUM_CLASSES; j++) begin
         if (frame_ok) window_logs[write_row][j] = log_type'(prob_ln_q10(probs[j*PROB_W +: PROB_W]));
         else window_logs[write_row][j] = log_type'(FLOOR_LOG);
      end
      write_row = (write_row + 1) % WINDOW_DEPTH;
      for (int j = 0; j < NUM_CLASSES; j++) begin
         sums[j] = 0;
         for (int i = 0; i < WINDOW_DEPTH; i++) sums[j] += window_logs[i][j];
      end
      // first maximum wins
      top_sum   = sums[0];
      top_class = 0;
      for (int j = 1; j < NUM_CLASSES; j++) begin
         if (sums[j] > top_sum) begin
            top_sum   = sums[j];
            top_class = j;
         end
      end
      d.detected = 1'b0;
      if (top_sum > int'(score_floor) && top_class != NUM_CLASSES - 1 &&
          (now_ms - last_hit_ms) > 32'(holdoff_ms)) begin
         d.detected  = 1'b1;
         last_hit_ms = now_ms;
      end
      d.best_class = CLASS_W'(top_class);
      d.best_sum   = SUM_W'(top_sum);
      return d;
   endfunction

   // Watch the three channels at each edge
   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++)
            for (int j = 0; j < NUM_CLASSES; j++) window_logs[i][j] = '0;
         write_row       = 0;
         last_hit_ms     = '0;
         score_floor     = -19'sd3072;
         holdoff_ms      = 16'd1000;
         error_count     = 0;
         results_checked = 0;
         detections_seen = 0;
         pending_decisions.delete();
      end else begin
         // result beat against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_decisions.size() == 0) begin
               $display("%0t ns: result beat with no frame waiting (detected %0b class %0d sum %0d)",
                        $time, rsp_detected, rsp_best_class, $signed(rsp_best_sum));
               error_count++;
            end else begin
               want = pending_decisions.pop_front();
               results_checked++;
               if (want.detected) detections_seen++;
               if (rsp_detected !== want.detected) begin
                  $display("%0t ns: detected expected %0b actual %0b",
                           $time, want.detected, rsp_detected);
                  error_count++;
               end
               if (rsp_best_class !== want.best_class) begin
                  $display("%0t ns: best_class expected %0d actual %0d",
                           $time, want.best_class, rsp_best_class);
                  error_count++;
               end
               if (rsp_best_sum !== want.best_sum) begin
                  $display("%0t ns: best_sum expected %0d actual %0d",
                           $time, $signed(want.best_sum), $signed(rsp_best_sum));
                  error_count++;
               end
            end
         end
         // frame beat
         if (req_valid && !req_stall)
            pending_decisions.push_back(window_decision(
               {req_class4_prob, req_class3_prob, req_class2_prob, req_class1_prob,
                req_class0_prob}, req_frame_valid, req_now_ms));
         // register write; spare indexes are ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: score_floor = sum_type'(csr_data);
               CSR_COOLDOWN:  holdoff_ms  = csr_data[COOL_W-1:0];
               default:       ;
            endcase
         end
      end
      outstanding = pending_decisions.size();
   end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the posterior window detector: drives frames and register writes, gives the verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pwcd_pkg::*;

   localparam int WINDOW_DEPTH    = 5;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 30;

   // Threshold far below any window sum, and the two unmapped indexes
   localparam logic [SUM_W-1:0]       THRESHOLD_MIN = SUM_W'(-226352);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI  = 2'd3;

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_stall;
   logic [PROB_W-1:0]      req_class0_prob = '0;
   logic [PROB_W-1:0]      req_class1_prob = '0;
   logic [PROB_W-1:0]      req_class2_prob = '0;
   logic [PROB_W-1:0]      req_class3_prob = '0;
   logic [PROB_W-1:0]      req_class4_prob = '0;
   logic                   req_frame_valid = 1'b0;
   logic [TIME_W-1:0]      req_now_ms      = '0;
   logic                   rsp_valid;
   logic                   rsp_stall       = 1'b0;
   logic                   rsp_detected;
   logic [CLASS_W-1:0]     rsp_best_class;
   logic [SUM_W-1:0]       rsp_best_sum;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index       = '0;
   logic [SUM_W-1:0]       csr_data        = '0;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned checked;
   int unsigned hits;

   int unsigned       frames_sent  = 0;
   int unsigned       settings_run = 0;
   bit                idle_on      = 1'b1;
   int unsigned       stall_left   = 0;
   int unsigned       burst_left   = 0;
   int unsigned       burst_class  = 0;
   logic [TIME_W-1:0] stamp_ms     = '0;

   posterior_window_command_detector #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dut (.*);

   pwcd_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_checker (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_class0_prob, .req_class1_prob, .req_class2_prob, .req_class3_prob,
      .req_class4_prob, .req_frame_valid, .req_now_ms,
      .rsp_valid, .rsp_stall, .rsp_detected, .rsp_best_class, .rsp_best_sum,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .error_count(mismatches), .outstanding(pending),
      .results_checked(checked), .detections_seen(hits)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver hold-off in random bursts
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: ends the run after too many cycles without any beat
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // One frame beat; returns at the edge that takes it, or after a random sender gap
   task automatic send_frame(input logic [PROB_W-1:0] p0, input logic [PROB_W-1:0] p1,
                             input logic [PROB_W-1:0] p2, input logic [PROB_W-1:0] p3,
                             input logic [PROB_W-1:0] p4, input logic frame_ok,
                             input logic [TIME_W-1:0] now_ms);
      req_valid       <= 1'b1;
      req_class0_prob <= p0;
      req_class1_prob <= p1;
      req_class2_prob <= p2;
      req_class3_prob <= p3;
      req_class4_prob <= p4;
      req_frame_valid <= frame_ok;
      req_now_ms      <= now_ms;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      frames_sent++;
      // sender gap
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every frame has its result
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [SUM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      // zero probabilities clamp to one LSB; window still holds its reset zeros
      send_frame(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 32'd0);
      send_frame(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1, 32'd2000);
      // leading-one positions around the 8-bit fraction boundary
      send_frame(16'd1, 16'd255, 16'd256, 16'd128, 16'hFFFF, 1'b1, 32'd2100);
      // bad frame forces the floor log whatever the probabilities
      send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd2200);
      // tie across all classes, then the noise class on top
      send_frame(16'd40000, 16'd40000, 16'd40000, 16'd40000, 16'd40000, 1'b1, 32'd3000);
      send_frame(16'd100, 16'd100, 16'd100, 16'd100, 16'hFFFF, 1'b1, 32'd5000);
      // steady keyword at one timestamp, so the last detection lands on 20000
      repeat (WINDOW_DEPTH)
         send_frame(16'd1000, 16'd1000, 16'hFFFF, 16'd1000, 16'd1000, 1'b1, 32'd20000);
      // cooldown: exactly 1000 ms is not enough, 1001 is
      send_frame(16'd1000, 16'd1000, 16'hFFFF, 16'd1000, 16'd1000, 1'b1, 32'd21000);
      send_frame(16'd1000, 16'd1000, 16'hFFFF, 16'd1000, 16'd1000, 1'b1, 32'd21001);
      // threshold: the class 2 window sum is 5 * -2 = -10
      drain();
      write_csr(CSR_THRESHOLD, SUM_W'(-10));
      send_frame(16'd1000, 16'd1000, 16'hFFFF, 16'd1000, 16'd1000, 1'b1, 32'd30000);
      drain();
      write_csr(CSR_THRESHOLD, SUM_W'(-11));
      send_frame(16'd1000, 16'd1000, 16'hFFFF, 16'd1000, 16'd1000, 1'b1, 32'd40000);
      // time difference across the 32-bit wrap
      send_frame(16'd1000, 16'd1000, 16'hFFFF, 16'd1000, 16'd1000, 1'b1, 32'hFFFF_FF00);
      send_frame(16'd1000, 16'd1000, 16'hFFFF, 16'd1000, 16'd1000, 1'b1, 32'h0000_02F0);
      // writes to unmapped indexes leave both registers alone
      drain();
      write_csr(CSR_SPARE_LO, 19'h7FFFF);
      write_csr(CSR_SPARE_HI, 19'h00000);
      send_frame(16'd1000, 16'd1000, 16'hFFFF, 16'd1000, 16'd1000, 1'b1, 32'h0000_0AF0);
      stamp_ms = 32'h0000_1000;
      settings_run = 3;
   endtask

   // Register setting for one phase of random frames
   task automatic configure_phase(input int ph);
      logic [SUM_W-1:0]  thr;
      logic [COOL_W-1:0] cool;
      case (ph)
         0:       begin thr = THRESHOLD_MIN;  cool = 16'd0;    end
         1:       begin thr = '0;             cool = 16'hFFFF; end
         2:       begin thr = SUM_W'(-3072);  cool = 16'd1000; end
         3: begin
            thr  = SUM_W'(-int'($urandom_range(100, 8000)));
            cool = COOL_W'($urandom_range(0, 2000));
         end
         4:       begin thr = SUM_W'($urandom); cool = COOL_W'($urandom); end
         5:       begin thr = SUM_W'(-2000);  cool = 16'd300;  end
         6:       begin thr = THRESHOLD_MIN;  cool = 16'hFFFF; end
         default: begin thr = SUM_W'(-4000);  cool = 16'd500;  end
      endcase
      drain();
      write_csr(CSR_COOLDOWN, {3'($urandom), cool});
      write_csr(CSR_THRESHOLD, thr);
      if ($urandom_range(0, 2) == 0)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, SUM_W'($urandom));
      settings_run++;
   endtask

   // Mostly keyword bursts with random content, the rest noise and edge values
   task automatic send_random_frame();
      logic [PROB_W-1:0] p [NUM_CLASSES];
      logic              frame_ok;
      logic [PROB_W-1:0] shared;
      int unsigned       pick;
      int unsigned       shape;
      pick = $urandom_range(0, 99);
      if (pick < 70) stamp_ms += $urandom_range(10, 40);
      else if (pick >= 80 && pick < 90) stamp_ms += $urandom_range(500, 2500);
      else if (pick >= 90 && pick < 95) stamp_ms = $urandom;
      else if (pick >= 95) stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      if (burst_left == 0 && $urandom_range(0, 99) < 65) begin
         burst_left  = $urandom_range(3, 12);
         burst_class = $urandom_range(0, NUM_CLASSES - 1);
      end
      if (burst_left != 0) begin
         burst_left--;
         for (int j = 0; j < NUM_CLASSES; j++)
            p[j] = (j == burst_class) ? PROB_W'($urandom_range(30000, 65535))
                                      : PROB_W'($urandom_range(0, 6000));
         frame_ok = ($urandom_range(0, 24) != 0);
      end else begin
         shape  = $urandom_range(0, 3);
         shared = PROB_W'($urandom);
         for (int j = 0; j < NUM_CLASSES; j++) begin
            case (shape)
               0, 1: p[j] = PROB_W'($urandom);
               2: begin
                  case ($urandom_range(0, 3))
                     0:       p[j] = '0;
                     1:       p[j] = '1;
                     2:       p[j] = PROB_W'(1) << $urandom_range(0, 15);
                     default: p[j] = (PROB_W'(1) << $urandom_range(0, 15)) - 1'b1;
                  endcase
               end
               default: p[j] = shared;
            endcase
         end
         frame_ok = ($urandom_range(0, 3) != 0);
      end
      send_frame(p[0], p[1], p[2], p[3], p[4], frame_ok, stamp_ms);
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // the last phase runs without any idling
         idle_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         configure_phase(ph);
         repeat (ITEMS_PER_PHASE) send_random_frame();
      end
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d frames under %0d register settings: edge values, cooldown, threshold,",
               frames_sent, settings_run);
      $display("time wrap, keyword bursts and noise; %0d results compared, %0d detections",
               checked, hits);
      if (mismatches == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ posterior_window_command_detector.f @@
hdl/pwcd_pkg.sv
hdl/pwcd_lane.sv
hdl/pwcd_merge.sv
hdl/posterior_window_command_detector.sv
hdl/pwcd_checker.sv
bench/pwcd_checker.sv
bench/tb_top.sv
